>>> src/dhcptt_pkg.sv
// Package for the DHCP server transaction tracker: transfer payload types,
// table entry and scan control structs, message and action codes.
// No dependencies.
package dhcptt_pkg;

   // DHCP message type codes
   localparam logic [7:0] MT_INVALID  = 8'd0;
   localparam logic [7:0] MT_DISCOVER = 8'd1;
   localparam logic [7:0] MT_REQUEST  = 8'd3;
   localparam logic [7:0] MT_DECLINE  = 8'd4;
   localparam logic [7:0] MT_RELEASE  = 8'd7;
   localparam logic [7:0] MT_INFORM   = 8'd8;

   // Server action codes
   localparam logic [2:0] ACT_DROP       = 3'd0;
   localparam logic [2:0] ACT_OFFER      = 3'd1;
   localparam logic [2:0] ACT_ACK        = 3'd2;
   localparam logic [2:0] ACT_INFORM_ACK = 3'd3;
   localparam logic [2:0] ACT_RELEASE    = 3'd4;

   localparam logic [15:0] LIFETIME_RESET = 16'd60;

   typedef struct packed {
      logic [31:0] now_secs;
      logic [47:0] hw_address;
      logic [31:0] transaction_id;
      logic [7:0]  message_type;
   } req_type;

   typedef struct packed {
      logic [2:0] action;
      logic       was_decline;
      logic       table_full;
   } rsp_type;

   // One table entry as held by a cell. Every entry left in the table was
   // opened by a discover (a request is acknowledged and released in the same
   // transfer), so no phase is stored.
   typedef struct packed {
      logic        valid;
      logic        pend_free;
      logic        pend_spare;
      logic [47:0] address;
      logic [31:0] txn_id;
      logic [31:0] created;
   } entry_type;

   // What the scan has seen so far for the current message.
   typedef struct packed {
      logic seen_first;
      logic matched;
      logic seen_hit;
      logic spare_found;
   } scan_flags_type;

   // End-of-scan update broadcast to every cell.
   typedef struct packed {
      logic        strobe;
      logic        free_en;
      logic        write_en;
      logic [47:0] address;
      logic [31:0] txn_id;
      logic [31:0] created;
   } commit_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT,
      ST_DELIVER
   } state_type;

   function automatic logic is_add_type(input logic [7:0] mt);
      return (mt == MT_DISCOVER) || (mt == MT_REQUEST);
   endfunction

endpackage

>>> src/dhcptt_cell.sv
// One table cell of the transaction ring: holds an entry, passes it on to
// its neighbor while the ring rotates and applies the end-of-scan update.
// Depends on dhcptt_pkg.
module dhcptt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  dhcptt_pkg::commit_type commit,
   input  dhcptt_pkg::entry_type upstream,
   output dhcptt_pkg::entry_type entry
);

   dhcptt_pkg::entry_type entry_ff;
   dhcptt_pkg::entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (shift_en) begin
         entry_in = upstream;
      end else if (commit.strobe) begin
         // A spare slot taken by a new discover wins over a pending free.
         if (entry_ff.pend_spare && commit.write_en) begin
            entry_in.valid   = 1'b1;
            entry_in.address = commit.address;
            entry_in.txn_id  = commit.txn_id;
            entry_in.created = commit.created;
         end else if (entry_ff.pend_free && commit.free_en) begin
            entry_in.valid = 1'b0;
         end
         entry_in.pend_free  = 1'b0;
         entry_in.pend_spare = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid      <= 1'b0;
         entry_ff.pend_free  <= 1'b0;
         entry_ff.pend_spare <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

>>> src/dhcptt_head.sv
// Head unit of the transaction ring: examines the entry leaving cell 0,
// tracks the lookup and add scan for the current message and hands the
// updated entry to the tail cell. Depends on dhcptt_pkg.
module dhcptt_head (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       step,
   input  dhcptt_pkg::req_type        query,
   input  logic [15:0]                lifetime,
   input  dhcptt_pkg::entry_type      entry_head,
   output dhcptt_pkg::entry_type      entry_tail,
   output dhcptt_pkg::scan_flags_type flags
);

   dhcptt_pkg::scan_flags_type flags_ff;
   dhcptt_pkg::scan_flags_type flags_in;
   dhcptt_pkg::scan_flags_type flags_step;
   dhcptt_pkg::entry_type      entry_out;
   logic [32:0]                expire_at;
   logic                       expired;
   logic                       addr_hit;
   logic                       add_type;

   always_comb begin
      expire_at = {1'b0, entry_head.created} + {17'd0, lifetime};
      expired   = entry_head.valid && ({1'b0, query.now_secs} > expire_at);
      addr_hit  = entry_head.valid && (entry_head.address == query.hw_address);
      add_type  = dhcptt_pkg::is_add_type(query.message_type);

      entry_out  = entry_head;
      flags_step = flags_ff;

      // Once the add has found its slot, or the lookup matched, the rest of
      // the table passes through unchanged.
      if (!flags_ff.seen_hit && !flags_ff.matched) begin
         if (addr_hit && !flags_ff.seen_first) begin
            flags_step.seen_first = 1'b1;
            if (expired) begin
               // The lookup frees an expired first match; the add scan then
               // sees it as a free slot.
               entry_out.valid = 1'b0;
               if (!flags_ff.spare_found) begin
                  entry_out.pend_spare   = 1'b1;
                  flags_step.spare_found = 1'b1;
               end
            end else if (entry_head.txn_id == query.transaction_id) begin
               flags_step.matched = 1'b1;
               if (query.message_type == dhcptt_pkg::MT_REQUEST) begin
                  entry_out.valid = 1'b0;
               end
            end else if (add_type) begin
               flags_step.seen_hit = 1'b1;
               if (query.message_type == dhcptt_pkg::MT_DISCOVER) begin
                  entry_out.txn_id  = query.transaction_id;
                  entry_out.created = query.now_secs;
               end else begin
                  entry_out.valid = 1'b0;
               end
            end
         end else if (addr_hit && !expired) begin
            if (add_type) begin
               flags_step.seen_hit = 1'b1;
               if (query.message_type == dhcptt_pkg::MT_DISCOVER) begin
                  entry_out.txn_id  = query.transaction_id;
                  entry_out.created = query.now_secs;
               end else begin
                  entry_out.valid = 1'b0;
               end
            end
         end else begin
            // Expired entries ahead of the slot are freed only if an add
            // really takes place, which is known at the end of the scan.
            if (expired) begin
               entry_out.pend_free = 1'b1;
            end
            if ((!entry_head.valid || expired) && !flags_ff.spare_found) begin
               entry_out.pend_spare   = 1'b1;
               flags_step.spare_found = 1'b1;
            end
         end
      end

      if (start) begin
         flags_in = '0;
      end else if (step) begin
         flags_in = flags_step;
      end else begin
         flags_in = flags_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   assign entry_tail = entry_out;
   assign flags      = flags_ff;

endmodule

>>> src/dhcp_server_transaction_tracker.sv
// Top level of the DHCP server transaction tracker: message and result
// channels, lifetime register, ring of table cells and scan sequencer.
// Depends on dhcptt_pkg, dhcptt_cell and dhcptt_head.
//
//   channel   direction  handshake                  payload
//   req       in         req_valid / req_ready      req_data (dhcptt_pkg::req_type)
//   rsp       out        rsp_valid / rsp_ready      rsp_data (dhcptt_pkg::rsp_type)
//   csr       in/out     psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// Between transfer and result, the table rotates once through the single
// compare unit in the head, then the commit state applies the deferred frees
// and the new entry. A message of type 0 skips the rotation and the commit
// state.
// Reset clears every valid bit at once, so the table is usable right away.
// A waiting result does not block the next transfer on req; the finished
// scan then holds until the output register is free.
module dhcp_server_transaction_tracker #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  dhcptt_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dhcptt_pkg::rsp_type rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam int CNT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);
   localparam logic CSR_IDX_LIFETIME = 1'b0;

   dhcptt_pkg::state_type      state_ff, state_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   dhcptt_pkg::req_type        query_ff, query_in;
   logic [15:0]                life_ff, life_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   dhcptt_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic                       accept;
   logic                       start;
   logic                       step;
   logic                       rsp_load;
   logic                       add_final;
   dhcptt_pkg::commit_type     commit;
   dhcptt_pkg::scan_flags_type flags;
   dhcptt_pkg::rsp_type        result;
   dhcptt_pkg::entry_type      tail_entry;
   dhcptt_pkg::entry_type      cell_entry [TABLE_ENTRIES];

   // Configuration port
   assign pready = 1'b1;

   always_comb begin
      life_in = life_ff;
      if (psel && penable && pwrite && (paddr[2] == CSR_IDX_LIFETIME)) begin
         life_in = pwdata[15:0];
      end
      if (paddr[2] == CSR_IDX_LIFETIME) begin
         prdata = {16'd0, life_ff};
      end else begin
         prdata = 32'd0;
      end
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      query_in  = query_ff;
      req_ready = 1'b0;
      start     = 1'b0;
      step      = 1'b0;
      rsp_load  = 1'b0;
      accept    = 1'b0;
      commit    = '0;

      add_final = dhcptt_pkg::is_add_type(query_ff.message_type) && !flags.matched;

      commit.free_en  = add_final;
      commit.write_en = add_final && !flags.seen_hit &&
                        (query_ff.message_type == dhcptt_pkg::MT_DISCOVER);
      commit.address  = query_ff.hw_address;
      commit.txn_id   = query_ff.transaction_id;
      commit.created  = query_ff.now_secs;

      unique case (state_ff)
         dhcptt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               accept   = 1'b1;
               start    = 1'b1;
               query_in = req_data;
               cnt_in   = '0;
               if (req_data.message_type == dhcptt_pkg::MT_INVALID) begin
                  state_in = dhcptt_pkg::ST_DELIVER;
               end else begin
                  state_in = dhcptt_pkg::ST_SCAN;
               end
            end
         end
         dhcptt_pkg::ST_SCAN: begin
            step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = dhcptt_pkg::ST_COMMIT;
            end
         end
         dhcptt_pkg::ST_COMMIT: begin
            commit.strobe = 1'b1;
            state_in      = dhcptt_pkg::ST_DELIVER;
         end
         dhcptt_pkg::ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = dhcptt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dhcptt_pkg::ST_IDLE;
         end
      endcase
   end

   // Server action from what the scan found
   always_comb begin
      result = '0;
      priority if (query_ff.message_type == dhcptt_pkg::MT_INVALID) begin
         result.action = dhcptt_pkg::ACT_DROP;
      end else if (flags.matched) begin
         // A stored discover met by a request is upgraded; anything else
         // repeats the offer.
         if (query_ff.message_type == dhcptt_pkg::MT_REQUEST) begin
            result.action = dhcptt_pkg::ACT_ACK;
         end else begin
            result.action = dhcptt_pkg::ACT_OFFER;
         end
      end else if (add_final) begin
         if (!flags.seen_hit && !flags.spare_found) begin
            result.action     = dhcptt_pkg::ACT_DROP;
            result.table_full = 1'b1;
         end else if (query_ff.message_type == dhcptt_pkg::MT_DISCOVER) begin
            result.action = dhcptt_pkg::ACT_OFFER;
         end else begin
            result.action = dhcptt_pkg::ACT_ACK;
         end
      end else if (query_ff.message_type == dhcptt_pkg::MT_INFORM) begin
         result.action = dhcptt_pkg::ACT_INFORM_ACK;
      end else if (query_ff.message_type == dhcptt_pkg::MT_DECLINE) begin
         result.action      = dhcptt_pkg::ACT_RELEASE;
         result.was_decline = 1'b1;
      end else if (query_ff.message_type == dhcptt_pkg::MT_RELEASE) begin
         result.action = dhcptt_pkg::ACT_RELEASE;
      end else begin
         result.action = dhcptt_pkg::ACT_DROP;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dhcptt_pkg::ST_IDLE;
         cnt_ff       <= '0;
         life_ff      <= dhcptt_pkg::LIFETIME_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         life_ff      <= life_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         query_ff <= query_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Ring of cells: entries move one place toward cell 0 per scan cycle and
   // come back to their own cell after a full turn through the head.
   dhcptt_head u_head (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .step       (step),
      .query      (query_ff),
      .lifetime   (life_ff),
      .entry_head (cell_entry[0]),
      .entry_tail (tail_entry),
      .flags      (flags)
   );

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      dhcptt_pkg::entry_type upstream;

      if (i == TABLE_ENTRIES - 1) begin : g_tail
         assign upstream = tail_entry;
      end else begin : g_link
         assign upstream = cell_entry[i+1];
      end

      dhcptt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (step),
         .commit   (commit),
         .upstream (upstream),
         .entry    (cell_entry[i])
      );
   end

endmodule
